/* rtl/core/alab_pkg.sv */
// shared widths, constants and interface types of the ambient light auto-brightness unit
package alab_pkg;

	localparam int LUX_W         = 16;
	localparam int BRIGHT_W      = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CURVE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(CURVE_ENTRIES);
	localparam int FACTOR_BITS   = 12;
	localparam int FACTOR_W      = FACTOR_BITS + 1;
	localparam int PROD_W        = FACTOR_W + BRIGHT_W;

	// register map of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LUX_MIN    = 2'd0,
		REG_LUX_MAX    = 2'd1,
		REG_BRIGHT_MIN = 2'd2,
		REG_BRIGHT_MAX = 2'd3
	} cfg_reg_t;

	// smoothing: new = (OLD_WEIGHT * old + target) / SMOOTH_DIV, OLD_WEIGHT a power of two
	localparam int SMOOTH_SHIFT  = 2;
	localparam int SMOOTH_DIV    = 5;
	localparam int SUM_W         = BRIGHT_W + SMOOTH_SHIFT + 1;

	// shared serial divider
	localparam int DIV_W         = LUX_W;
	localparam int DVD_W         = (SUM_W > IDX_W) ? SUM_W : IDX_W;
	localparam int STEP_W        = $clog2(DVD_W + 1);

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DVD_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} alab_div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} alab_div_rsp_t;

endpackage

/* rtl/core/alab_serial_div.sv */
// restoring divider, one quotient bit per cycle
module alab_serial_div
	import alab_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  alab_div_cmd_t cmd,
	output alab_div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quot_q;

	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= cmd.rem_init;
			div_q  <= cmd.divisor;
			dvd_q  <= cmd.dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			quot_q <= {quot_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* rtl/core/alab_serial_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, msb first
module alab_serial_mul
	import alab_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [FACTOR_W-1:0] factor,
	input  logic [BRIGHT_W-1:0] span,
	output logic                done,
	output logic [PROD_W-1:0]   product
);

	localparam int CNT_W = $clog2(BRIGHT_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FACTOR_W-1:0] fac_q;
	logic [BRIGHT_W-1:0] span_q;
	logic [PROD_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BRIGHT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fac_q  <= factor;
			span_q <= span;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q  <= {acc_q[PROD_W-2:0], 1'b0}
				+ (span_q[BRIGHT_W-1] ? {{BRIGHT_W{1'b0}}, fac_q} : '0);
			span_q <= {span_q[BRIGHT_W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

/* rtl/core/alab_curve_rom.sv */
// power-curve rom, round(2^FACTOR_BITS * (i / (entries - 1))^0.6), registered read
module alab_curve_rom
	import alab_pkg::*;
(
	input  logic                clk,
	input  logic [IDX_W-1:0]    addr,
	output logic [FACTOR_W-1:0] data
);

	localparam int CALC_W = 5 * (FACTOR_BITS + 2) + 3 * IDX_W + 8;

	typedef logic [FACTOR_W-1:0] curve_t [CURVE_ENTRIES];

	// round(v) >= y exactly when (2y-1)^5 (N-1)^3 <= 32 S^5 i^3, binary search on y
	function automatic curve_t build_curve();
		curve_t          rom;
		logic [CALC_W-1:0] rhs;
		logic [CALC_W-1:0] lhs;
		int              i;
		int              k;
		int              lo;
		int              hi;
		int              mid;
		for (i = 0; i < CURVE_ENTRIES; i++) begin
			rhs = CALC_W'(32) << (5 * FACTOR_BITS);
			for (k = 0; k < 3; k++) begin
				rhs = rhs * CALC_W'(i);
			end
			lo = 0;
			hi = 1 << FACTOR_BITS;
			while (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				lhs = CALC_W'(1);
				for (k = 0; k < 5; k++) begin
					lhs = lhs * CALC_W'(2 * mid - 1);
				end
				for (k = 0; k < 3; k++) begin
					lhs = lhs * CALC_W'(CURVE_ENTRIES - 1);
				end
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			rom[i] = FACTOR_W'(lo);
		end
		return rom;
	endfunction

	localparam curve_t CURVE = build_curve();

	logic [FACTOR_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= CURVE[addr];
	end

	assign data = data_q;

endmodule

/* rtl/core/ambient_light_auto_brightness_unit.sv */
// top level of the ambient light auto-brightness unit: control sequencer, registers, output stage
//
// One lux sample in, one smoothed brightness level out. The sample is clamped to
// [lux_min, lux_max] and normalised to a 10-bit curve index by a restoring divider
// that yields one quotient bit a cycle; the index reads a power-curve rom (exponent 0.6,
// Q1.12), the factor scales the brightness span in a bit-serial shift-add multiplier,
// and the target is blended into the stored level as (4*old + target)/5 through the same
// divider. The index divide is skipped when the sample sits at or above lux_max (or the
// lux range is empty), and the index divide (10 steps), the multiply (8 steps) and the
// smoothing divide (11 steps) set how long a sample takes from input to output.
// One sample is worked on at a time; a finished level waits in the output register
// while the next sample is taken. The configuration channel is always ready and should
// be written only while no sample is in flight.
module ambient_light_auto_brightness_unit
	import alab_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] lux
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] brightness
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LUX_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_IDX,
		S_ROM,
		S_FETCH,
		S_MUL,
		S_SMOOTH,
		S_OUT
	} state_t;

	// configuration registers
	logic [LUX_W-1:0]    lux_min_q;
	logic [LUX_W-1:0]    lux_max_q;
	logic [BRIGHT_W-1:0] bright_min_q;
	logic [BRIGHT_W-1:0] bright_max_q;

	// sequencer and datapath registers
	state_t              state_q;
	logic [LUX_W-1:0]    lux_q;
	logic [IDX_W-1:0]    idx_q;
	logic [BRIGHT_W-1:0] smoothed_q;
	logic                mul_start_q;
	alab_div_cmd_t       div_cmd_q;
	logic                m_tvalid_q;
	logic [BRIGHT_W-1:0] m_tdata_q;

	alab_div_rsp_t       div_rsp;
	logic [FACTOR_W-1:0] factor;
	logic                mul_done;
	logic [PROD_W-1:0]   product;

	logic                zero_range;
	logic                at_top;
	logic [LUX_W-1:0]    lux_low;
	logic [LUX_W-1:0]    lux_off;
	logic [LUX_W-1:0]    lux_range;
	logic [BRIGHT_W-1:0] span;
	logic [BRIGHT_W-1:0] target;
	logic [SUM_W-1:0]    blend_sum;
	logic                out_free;
	logic                cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// register writes, any index is one of the four
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lux_min_q    <= LUX_W'(0);
			lux_max_q    <= LUX_W'(1000);
			bright_min_q <= BRIGHT_W'(10);
			bright_max_q <= BRIGHT_W'(255);
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LUX_MIN:    lux_min_q    <= cfg_data;
				REG_LUX_MAX:    lux_max_q    <= cfg_data;
				REG_BRIGHT_MIN: bright_min_q <= cfg_data[BRIGHT_W-1:0];
				REG_BRIGHT_MAX: bright_max_q <= cfg_data[BRIGHT_W-1:0];
				default:        ;
			endcase
		end
	end

	// clamp and normalise set-up: the top end of the range maps straight to the last entry
	always_comb begin
		zero_range = (lux_max_q <= lux_min_q);
		at_top     = (lux_q >= lux_max_q);
		lux_low    = (lux_q < lux_min_q) ? lux_min_q : lux_q;
		lux_off    = lux_low - lux_min_q;
		lux_range  = lux_max_q - lux_min_q;
	end

	// an inverted brightness range counts as zero span
	assign span = (bright_max_q >= bright_min_q) ? (bright_max_q - bright_min_q) : '0;

	// the factor never exceeds 1.0, so the target stays within bright_max unless the brightness range is inverted
	always_comb begin
		target    = bright_min_q + product[FACTOR_BITS +: BRIGHT_W];
		blend_sum = {1'b0, smoothed_q, {SMOOTH_SHIFT{1'b0}}} + SUM_W'(target);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			smoothed_q  <= '0;
			mul_start_q <= 1'b0;
			div_cmd_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			lux_q       <= '0;
			idx_q       <= '0;
		end else begin
			mul_start_q     <= 1'b0;
			div_cmd_q.start <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						lux_q   <= s_tdata[LUX_W-1:0];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (zero_range) begin
						idx_q   <= '0;
						state_q <= S_ROM;
					end else if (at_top) begin
						idx_q   <= IDX_W'(CURVE_ENTRIES - 1);
						state_q <= S_ROM;
					end else begin
						// offset below range: fraction bits only, shifted in as zeros
						div_cmd_q.start    <= 1'b1;
						div_cmd_q.rem_init <= lux_off;
						div_cmd_q.dividend <= '0;
						div_cmd_q.divisor  <= lux_range;
						div_cmd_q.steps    <= STEP_W'(IDX_W);
						state_q            <= S_IDX;
					end
				end
				S_IDX: begin
					if (div_rsp.done) begin
						idx_q   <= div_rsp.quot[IDX_W-1:0];
						state_q <= S_ROM;
					end
				end
				S_ROM: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					mul_start_q <= 1'b1;
					state_q     <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						div_cmd_q.start    <= 1'b1;
						div_cmd_q.rem_init <= '0;
						div_cmd_q.dividend <= DVD_W'(blend_sum);
						div_cmd_q.divisor  <= DIV_W'(SMOOTH_DIV);
						div_cmd_q.steps    <= STEP_W'(SUM_W);
						state_q            <= S_SMOOTH;
					end
				end
				S_SMOOTH: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// quotient holds until the next divide is started
					if (out_free) begin
						smoothed_q <= div_rsp.quot[BRIGHT_W-1:0];
						m_tdata_q  <= div_rsp.quot[BRIGHT_W-1:0];
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	alab_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd_q),
		.rsp    (div_rsp)
	);

	alab_curve_rom u_rom (
		.clk  (clk),
		.addr (idx_q),
		.data (factor)
	);

	alab_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.factor  (factor),
		.span    (span),
		.done    (mul_done),
		.product (product)
	);

`ifndef SYNTH
	// divider results only come back while a divide is awaited
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_IDX || state_q == S_SMOOTH))
		else $error("divider result outside a divide state");

	// multiplier result only comes back while the multiply is awaited
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("multiplier result outside the multiply state");

	// an input transfer starts the clamp step
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_PREP))
		else $error("input transfer did not start a sample");

	// a published level is also the stored smoothing state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (m_tvalid && m_tdata == smoothed_q))
		else $error("published level differs from stored level");
`endif

endmodule
